>>> rtl/core/frnc_pkg.sv
package frnc_pkg;

    localparam int COUNT_W        = 11;
    localparam int INDEX_W        = 10;
    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 16;
    localparam int POINT_W        = 2 * COORD_W;
    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int             PADDR_W          = 3;
    localparam logic           REG_POINT_COUNT  = 1'b0;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_BAD   = 2'd2
    } op_code_t;

    typedef struct packed {
        op_code_t                   code;
        logic [INDEX_W-1:0]         index;
        logic [COORD_W-1:0]         x_coord;
        logic [COORD_W-1:0]         y_coord;
        logic [RADIUS_W-1:0]        radius;
    } op_t;

    // width that holds both the point count register and MAX_POINTS itself
    function automatic int limit_width(input int max_points);
        int cw;
        begin
            cw = $clog2(max_points + 1);
            return (cw > COUNT_W) ? cw : COUNT_W;
        end
    endfunction

endpackage

>>> rtl/core/frnc_ram.sv
module frnc_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/frnc_front.sv
module frnc_front
    import frnc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int LW         = limit_width(MAX_POINTS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [LW-1:0]       limit,
    input  logic                s_valid,
    output logic                s_ready,
    input  op_t                 s_op,
    output logic                q_valid,
    input  logic                q_ready,
    output op_t                 q_op
);

    op_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    op_t               classified;
    logic              keep;
    logic              push;
    logic              pop;

    // classify: drop loads beyond the store, flag queries beyond the limit
    always_comb
    begin
        classified = s_op;
        keep       = 1'b1;
        case (s_op.code)
            OP_LOAD:
            begin
                keep = (LW'(s_op.index) < LW'(MAX_POINTS));
            end
            OP_QUERY:
            begin
                if (LW'(s_op.index) >= limit)
                begin
                    classified.code = OP_BAD;
                end
            end
            default:
            begin
                classified.code = OP_BAD;
            end
        endcase
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_op    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            case ({push, pop})
                2'b10:   count_reg <= QCNT_W'(count_reg + 1'b1);
                2'b01:   count_reg <= QCNT_W'(count_reg - 1'b1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == QCNT_W'(QUEUE_DEPTH))
        || (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready && !keep && !pop) |=> $stable(count_reg))
        else $error("dropped load changed the queue");
`endif

endmodule

>>> rtl/core/frnc_back.sv
module frnc_back
    import frnc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int LW         = limit_width(MAX_POINTS),
    parameter int AW         = $clog2(MAX_POINTS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LW-1:0]      limit,
    input  logic               q_valid,
    output logic               q_ready,
    input  op_t                q_op,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [POINT_W-1:0] ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [POINT_W-1:0] ram_rdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_bad
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CENTER = 3'b010,
        ST_SCAN   = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LW-1:0]        iss_reg;
    logic [2*RADIUS_W-1:0] rr_reg;
    logic [COORD_W-1:0]   cx_reg;
    logic [COORD_W-1:0]   cy_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 hit_reg;
    logic signed [COORD_W:0] dx_reg;
    logic signed [COORD_W:0] dy_reg;
    logic [2*COORD_W-1:0] sqx_reg;
    logic [2*COORD_W-1:0] sqy_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;
    logic                 out_bad_reg;

    logic                 pop;
    logic                 issue;
    logic                 scan_done;
    logic signed [COORD_W:0]     dx_next;
    logic signed [COORD_W:0]     dy_next;
    logic signed [2*COORD_W+1:0] px_prod;
    logic signed [2*COORD_W+1:0] py_prod;
    logic [2*COORD_W:0]   sum_sq;

    // take a load whenever idle; a query only when the result register is also free
    assign pop = q_valid && (state_reg == ST_IDLE)
                 && ((q_op.code == OP_LOAD) || !out_valid_reg);
    assign q_ready = pop;

    assign ram_we    = pop && (q_op.code == OP_LOAD);
    assign ram_waddr = AW'(q_op.index);
    assign ram_wdata = {q_op.y_coord, q_op.x_coord};
    assign ram_raddr = (state_reg == ST_IDLE) ? AW'(q_op.index) : iss_reg[AW-1:0];

    assign issue     = (state_reg == ST_SCAN) && (iss_reg < limit);
    assign scan_done = (state_reg == ST_SCAN) && (iss_reg == limit)
                       && !v1_reg && !v2_reg && !v3_reg && !hit_reg;

    assign dx_next = {cx_reg[COORD_W-1], cx_reg}
                     - {ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]};
    assign dy_next = {cy_reg[COORD_W-1], cy_reg}
                     - {ram_rdata[POINT_W-1], ram_rdata[POINT_W-1:COORD_W]};
    assign px_prod = dx_reg * dx_reg;
    assign py_prod = dy_reg * dy_reg;
    assign sum_sq  = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (q_op.code == OP_QUERY))
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload of the scan pipeline
    always_ff @(posedge clk)
    begin
        if (pop && (q_op.code == OP_QUERY))
        begin
            rr_reg <= q_op.radius * q_op.radius;
        end
        if (state_reg == ST_CENTER)
        begin
            cx_reg <= ram_rdata[COORD_W-1:0];
            cy_reg <= ram_rdata[POINT_W-1:COORD_W];
        end
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= px_prod[2*COORD_W-1:0];
        sqy_reg <= py_prod[2*COORD_W-1:0];
        if (scan_done)
        begin
            out_cnt_reg <= cnt_reg;
            out_bad_reg <= 1'b0;
        end
        else if (pop && (q_op.code == OP_BAD))
        begin
            out_cnt_reg <= '0;
            out_bad_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CENTER)
            begin
                iss_reg <= '0;
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                iss_reg <= LW'(iss_reg + 1'b1);
            end
            v1_reg  <= issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            hit_reg <= v3_reg && (sum_sq < {1'b0, rr_reg});
            if (hit_reg && (cnt_reg != COUNT_MAX) && (state_reg == ST_SCAN))
            begin
                cnt_reg <= COUNT_W'(cnt_reg + 1'b1);
            end
            if (scan_done || (pop && (q_op.code == OP_BAD)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_count = out_cnt_reg;
    assign m_bad   = out_bad_reg;

`ifndef SYNTHESIS
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_reg <= limit))
        else $error("scan address ran past the limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (LW'(cnt_reg) <= iss_reg))
        else $error("neighbor count exceeds scanned points");

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (q_op.code == OP_BAD)) |=> (out_valid_reg && out_bad_reg
                                            && (out_cnt_reg == '0)))
        else $error("bad query gave no error result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_done) |-> (!out_valid_reg))
        else $error("result register overwritten");
`endif

endmodule

>>> rtl/core/fixed_radius_neighbour_count.sv
// Load: written to the point store at the edge it leaves the queue; one load per cycle when idle.
// Query: reads its centre, then scans the clamped point_count stored points to the result, one stored
//   point read per cycle; the next query leaves the queue only once the result has been taken.
// Bad query index: result in the cycle after leaving the queue; a 2-entry queue sits in front.
// Reset (rst_n, asynchronous, active low) clears point_count, the queue and all control;
//   the point store is not cleared and holds no valid data until loaded.
module fixed_radius_neighbour_count
    import frnc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // point_index[9:0], x_coord[25:10], y_coord[41:26], radius[57:42], zero fill
    input  logic [63:0]        s_axis_tdata,
    // kind[0]
    input  logic               s_axis_tuser,
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // neighbour_count[10:0], zero fill
    output logic [15:0]        m_axis_tdata,
    // bad_index[0]
    output logic               m_axis_tuser
);

    localparam int LW = limit_width(MAX_POINTS);
    localparam int AW = $clog2(MAX_POINTS);

    logic [COUNT_W-1:0] point_count_reg;
    logic [LW-1:0]      limit;
    logic               cfg_write;
    op_t                in_op;
    logic               q_valid;
    logic               q_ready;
    op_t                q_op;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [POINT_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [POINT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] res_count;

    // Register write completes on the access cycle; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_POINT_COUNT))
        begin
            point_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_reg) : 32'd0;

    // Clamp the count to the store size; it bounds both the scan and the index check.
    assign limit = (LW'(point_count_reg) > LW'(MAX_POINTS)) ? LW'(MAX_POINTS)
                                                             : LW'(point_count_reg);

    // Unpack the input transfer into an operation.
    always_comb
    begin
        in_op.code    = (s_axis_tuser == KIND_QUERY) ? OP_QUERY : OP_LOAD;
        in_op.index   = s_axis_tdata[9:0];
        in_op.x_coord = s_axis_tdata[25:10];
        in_op.y_coord = s_axis_tdata[41:26];
        in_op.radius  = s_axis_tdata[57:42];
    end

    // Front: accept, classify and queue.
    frnc_front #(
        .MAX_POINTS (MAX_POINTS),
        .LW         (LW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_op    (in_op),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_op    (q_op)
    );

    // Back: store loads, run the scan pipeline, hold the result.
    frnc_back #(
        .MAX_POINTS (MAX_POINTS),
        .LW         (LW),
        .AW         (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_count   (res_count),
        .m_bad     (m_axis_tuser)
    );

    // Point store: x in the low half, y in the high half.
    frnc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tdata = 16'(res_count);

endmodule

>>> tb/tb_fixed_radius_neighbour_count.sv
module tb_fixed_radius_neighbour_count;
    import frnc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // Slowest legal run: about 1630 transfers, of which at most about 610 are
    // queries. A query scans at most MAX_POINTS entries, and each transfer can
    // also sit behind a sender gap and a receiver stall; this limit leaves a
    // wide margin over that.
    localparam int CYCLE_LIMIT  = 5_000_000;
    // At most two loads can still wait in the queue, each written as it leaves;
    // keep a wide margin before any register write.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 580;
    localparam int LOG_CAP       = 100;
    localparam int INDEX_MAX     = MAX_POINTS_DEF - 1;
    localparam int TDATA_FILL    = 64 - INDEX_W - 2 * COORD_W - RADIUS_W;

    localparam logic [PADDR_W-1:0]  ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
    localparam logic [RADIUS_W-1:0] RADIUS_MAX       = {RADIUS_W{1'b1}};

    typedef struct {
        logic                kind;
        logic [INDEX_W-1:0]  index;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [RADIUS_W-1:0] radius;
    } point_op_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               bad_index;
    } count_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // point_index[9:0], x_coord[25:10], y_coord[41:26], radius[57:42], zero fill
    logic [63:0]        s_axis_tdata;
    // kind[0]
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // neighbour_count[10:0], zero fill
    logic [15:0]        m_axis_tdata;
    // bad_index[0]
    logic               m_axis_tuser;

    // Shadow of the block: point table, point_count and the results owed.
    logic [POINT_W-1:0] point_shadow [MAX_POINTS_DEF];
    logic [COUNT_W-1:0] count_shadow = '0;
    count_result_t      expected_counts [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int tx_burst_left = 0;
    int tx_gap_max    = 0;
    int rx_stall_max  = 0;
    int rx_run        = 0;
    bit rx_ready_phase = 1'b1;

    fixed_radius_neighbour_count u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: fail the run at the cycle limit, as when the handshakes stop making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_fixed_radius_neighbour_count: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        // hold the log to a readable size on a badly broken build
        if (error_count <= LOG_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Apply one accepted transfer to the shadow state. Return 1 and the
    // expected result for a query; a load updates the table and owes nothing.
    function automatic bit predict_neighbours(input point_op_t op,
                                              output count_result_t res);
        int                 limit;
        longint             dx;
        longint             dy;
        longint             radius_sq;
        logic [POINT_W-1:0] centre;
        logic [COUNT_W-1:0] hits;
        res.count     = '0;
        res.bad_index = 1'b0;
        if (op.kind == KIND_LOAD)
        begin
            point_shadow[op.index] = {op.y_coord, op.x_coord};
            return 1'b0;
        end
        // a count above the table size scans the whole table
        limit = (count_shadow > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(count_shadow);
        if (int'(op.index) >= limit)
        begin
            res.bad_index = 1'b1;
            return 1'b1;
        end
        centre    = point_shadow[op.index];
        radius_sq = longint'(op.radius) * longint'(op.radius);
        hits      = '0;
        for (int i = 0; i < limit; i++)
        begin
            dx = longint'($signed(centre[COORD_W-1:0]))
               - longint'($signed(point_shadow[i][COORD_W-1:0]));
            dy = longint'($signed(centre[POINT_W-1:COORD_W]))
               - longint'($signed(point_shadow[i][POINT_W-1:COORD_W]));
            // strict compare on squared distance; saturate the count
            if (dx * dx + dy * dy < radius_sq && hits != COUNT_MAX)
                hits++;
        end
        res.count = hits;
        return 1'b1;
    endfunction

    function automatic point_op_t load_op(input int idx, input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
        point_op_t op;
        op.kind    = KIND_LOAD;
        op.index   = INDEX_W'(idx);
        op.x_coord = x;
        op.y_coord = y;
        op.radius  = RADIUS_W'($urandom);
        return op;
    endfunction

    function automatic point_op_t query_op(input int idx, input logic [RADIUS_W-1:0] r);
        point_op_t op;
        op.kind    = KIND_QUERY;
        op.index   = INDEX_W'(idx);
        op.x_coord = COORD_W'($urandom);
        op.y_coord = COORD_W'($urandom);
        op.radius  = r;
        return op;
    endfunction

    // Coordinate near a cluster centre, with the odd point anywhere in range.
    function automatic logic [COORD_W-1:0] pick_coord(input int centre, input int spread);
        int v;
        if ($urandom_range(0, 15) == 0)
            return COORD_W'($urandom);
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return COORD_W'(v);
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius(input int spread);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return RADIUS_MAX;
        return RADIUS_W'($urandom_range(1, (2 * spread > 65535) ? 65535 : 2 * spread));
    endfunction

    // Send one transfer. The sender runs in bursts; between bursts drop
    // tvalid for a random gap. tvalid stays high between items of a burst.
    task automatic send_op(input point_op_t op);
        int            gap;
        count_result_t res;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        tx_burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.kind;
        s_axis_tdata  <= {{TDATA_FILL{1'b0}}, op.radius, op.y_coord, op.x_coord, op.index};
        do @(posedge clk); while (!s_axis_tready);
        if (predict_neighbours(op, res))
            expected_counts = {expected_counts, res};
    endtask

    // Stop sending and wait for every owed result, then let any trailing
    // load retire so the block is idle.
    task automatic drain_results;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        tx_burst_left = 0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write point_count with junk in the unused upper bits, then read it back.
    task automatic write_point_count(input logic [COUNT_W-1:0] value);
        logic [31:0] word;
        word = $urandom;
        word[COUNT_W-1:0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POINT_COUNT;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        count_shadow = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[COUNT_W-1:0] !== value)
            report_mismatch($sformatf("point_count read back %0d, wrote %0d",
                                      prdata[COUNT_W-1:0], value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: alternate ready and stall stretches of random length, or
    // stay ready throughout when rx_stall_max is zero.
    always @(negedge clk)
    begin
        if (rx_stall_max == 0)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (rx_run == 0)
        begin
            rx_ready_phase = !rx_ready_phase;
            rx_run = rx_ready_phase ? $urandom_range(1, 8) : $urandom_range(1, rx_stall_max);
            m_axis_tready <= rx_ready_phase;
        end
        else
        begin
            rx_run--;
        end
    end

    // Check every result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        count_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("result with none owed: count %0d bad_index %0b",
                                          m_axis_tdata[COUNT_W-1:0], m_axis_tuser));
            end
            else
            begin
                want = expected_counts.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== want.count)
                    report_mismatch($sformatf("neighbour_count %0d, expected %0d",
                                              m_axis_tdata[COUNT_W-1:0], want.count));
                if (m_axis_tuser !== want.bad_index)
                    report_mismatch($sformatf("bad_index %0b, expected %0b",
                                              m_axis_tuser, want.bad_index));
            end
        end
    end

    // Field extremes, zero radius, the strict boundary and index checks.
    task automatic test_directed_cases;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        // point_count is zero out of reset, so every query is out of range
        send_op(query_op(0, 16'h0100));
        send_op(query_op(INDEX_MAX, RADIUS_MAX));
        send_op(load_op(0, 16'h0000, 16'h0000));
        send_op(load_op(1, 16'h7FFF, 16'h7FFF));
        send_op(load_op(2, 16'h8000, 16'h8000));
        send_op(load_op(3, 16'h0001, 16'hFFFF));
        send_op(load_op(4, 16'h8000, 16'h7FFF));
        send_op(load_op(5, 16'h0100, 16'h0000));
        send_op(load_op(INDEX_MAX, 16'h5555, 16'hAAAA));
        drain_results;
        write_point_count(COUNT_W'(6));
        send_op(query_op(0, 16'h0000));         // zero radius: nothing qualifies
        send_op(query_op(0, 16'h0001));         // only the point itself
        send_op(query_op(0, 16'h0100));         // neighbor exactly on the radius
        send_op(query_op(5, 16'h0101));         // same neighbor just inside
        send_op(query_op(1, RADIUS_MAX));
        send_op(query_op(2, RADIUS_MAX));       // opposite corner out of reach
        send_op(query_op(4, RADIUS_MAX));
        send_op(query_op(6, 16'h0001));         // index equal to point_count
        send_op(query_op(INDEX_MAX, 16'h0001));
        drain_results;
    endtask

    // Fill the whole table, then scan it at full size and with point_count
    // above the table size. Every entry is written from here on, so later
    // phases may query any index inside point_count.
    task automatic test_full_store;
        tx_gap_max   = 2;
        rx_stall_max = 4;
        for (int i = 0; i < MAX_POINTS_DEF; i++)
            send_op(load_op(i, pick_coord(0, 2048), pick_coord(0, 2048)));
        drain_results;
        write_point_count(COUNT_W'(MAX_POINTS_DEF));
        send_op(query_op(0, pick_radius(2048)));
        send_op(query_op(INDEX_MAX, pick_radius(2048)));
        send_op(query_op($urandom_range(0, INDEX_MAX), RADIUS_MAX));
        send_op(query_op($urandom_range(0, INDEX_MAX), RADIUS_W'($urandom_range(1, 4096))));
        drain_results;
        write_point_count(COUNT_MAX);
        send_op(query_op(INDEX_MAX, RADIUS_W'($urandom_range(1, 4096))));
        send_op(query_op($urandom_range(0, INDEX_MAX), pick_radius(2048)));
        drain_results;
        write_point_count(COUNT_W'(MAX_POINTS_DEF + 1));
        send_op(query_op($urandom_range(0, INDEX_MAX), RADIUS_W'($urandom_range(1, 4096))));
        drain_results;
    endtask

    // Phases of mixed loads and queries, each with its own point_count,
    // cluster, sender gaps and receiver stalls.
    task automatic test_random_traffic;
        int sent;
        int phase;
        int span;
        int spread;
        int cx;
        int cy;
        int roll;
        int n_ops;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results;
            roll = $urandom_range(0, 99);
            if (phase == 0)
                span = 0;
            else if (phase == 1)
                span = 1;
            else if (roll < 60)
                span = $urandom_range(2, 40);
            else if (roll < 88)
                span = $urandom_range(41, 160);
            else if (roll < 97)
                span = $urandom_range(161, 400);
            else
                span = MAX_POINTS_DEF;
            write_point_count(COUNT_W'(span));
            tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            case ($urandom_range(0, 3))
                0: spread = 16;
                1: spread = 128;
                2: spread = 1024;
                default: spread = 8192;
            endcase
            cx    = int'($urandom_range(0, 4096)) - 2048;
            cy    = int'($urandom_range(0, 4096)) - 2048;
            n_ops = $urandom_range(30, 70);
            for (int k = 0; k < n_ops && sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    // mostly rewrite points inside the window, sometimes anywhere
                    if (span > 0 && $urandom_range(0, 4) != 0)
                        send_op(load_op($urandom_range(0, span - 1),
                                        pick_coord(cx, spread), pick_coord(cy, spread)));
                    else
                        send_op(load_op($urandom_range(0, INDEX_MAX),
                                        pick_coord(cx, spread), pick_coord(cy, spread)));
                end
                else if (roll < 90 || span >= MAX_POINTS_DEF)
                begin
                    if (span > 0)
                        send_op(query_op($urandom_range(0, span - 1), pick_radius(spread)));
                    else
                        send_op(query_op($urandom_range(0, INDEX_MAX), pick_radius(spread)));
                end
                else
                begin
                    send_op(query_op($urandom_range(span, INDEX_MAX), pick_radius(spread)));
                end
                sent++;
                // now and then hold the sender until the block has caught up
                if ($urandom_range(0, 39) == 0)
                    drain_results;
            end
            phase++;
        end
        drain_results;
    endtask

    initial
    begin
        // drive every input to a known value from time zero
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_LOAD;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < MAX_POINTS_DEF; i++)
            point_shadow[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases;
        test_full_store;
        test_random_traffic;

        if (expected_counts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
        if (error_count == 0)
            $display("tb_fixed_radius_neighbour_count: PASS");
        else
            $display("tb_fixed_radius_neighbour_count: FAIL");
        $finish;
    end

endmodule
